[hw/rtl/vna_pkg.sv]
// Shared types and constants for the vertex normal accumulator.
// No dependencies; imported by the normal store, index wrap and top level.
`timescale 1ns / 1ps

package vna_pkg;

  // Width of the raw index fields on the input channel.
  localparam int RAW_IDX_W = 10;
  // Width of the coordinate fields on the input channel (Q8.8).
  localparam int FIELD_CW  = 16;
  // Accumulator width (Q32.16).
  localparam int ACC_W     = 48;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } acc_vec_t;

  // Normal store request, one of the three at a time.
  typedef struct packed {
    logic rd_en;
    logic acc_en;
    logic clr_en;
  } nrm_req_t;

endpackage

[hw/rtl/vna_wrap.sv]
// Reduces a raw 10-bit index modulo a store depth in two registered steps.
// Quotient by reciprocal multiply, then one correcting subtract. Uses vna_pkg.
`timescale 1ns / 1ps

module vna_wrap import vna_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [RAW_IDX_W-1:0]     raw_i,
  output logic [$clog2(DEPTH)-1:0] idx_o
);

  localparam int SHIFT = 20;
  localparam int RECIP = (1 << SHIFT) / DEPTH;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int DW    = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PW    = RAW_IDX_W + RW;
  localparam int QW    = RAW_IDX_W + DW;

  logic [RAW_IDX_W-1:0] raw_q;
  logic [RAW_IDX_W-1:0] q_q;
  logic [IDX_W-1:0]     idx_q;

  logic [PW-1:0]        prod;
  logic [RAW_IDX_W-1:0] q_d;
  logic [QW-1:0]        qd;
  logic [RAW_IDX_W-1:0] rem;
  logic [RAW_IDX_W-1:0] rem_fin;

  // Floor reciprocal: estimate is the true quotient or one less.
  assign prod = PW'(raw_q) * PW'(RECIP);
  assign q_d  = RAW_IDX_W'(prod >> SHIFT);
  assign qd   = QW'(q_q) * QW'(DEPTH);
  assign rem  = raw_q - qd[RAW_IDX_W-1:0];

  always_comb begin
    rem_fin = rem;
    if (QW'(rem) >= QW'(DEPTH)) begin
      rem_fin = rem - RAW_IDX_W'(DEPTH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= raw_i;
    end
    q_q   <= q_d;
    idx_q <= IDX_W'(rem_fin);
  end

  assign idx_o = idx_q;

endmodule

[hw/rtl/vna_vertex_mem.sv]
// Vertex position store: one write port, one read port, registered read data.
// Holds x, y and z of a vertex in one word. No package dependency.
`timescale 1ns / 1ps

module vna_vertex_mem #(
  parameter int DEPTH = 1024,
  parameter int CW    = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic signed [CW-1:0]     wx_i,
  input  logic signed [CW-1:0]     wy_i,
  input  logic signed [CW-1:0]     wz_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic signed [CW-1:0]     rx_o,
  output logic signed [CW-1:0]     ry_o,
  output logic signed [CW-1:0]     rz_o
);

  logic [3*CW-1:0] mem [DEPTH];
  logic [3*CW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wx_i, wy_i, wz_i};
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rx_o = rdata_q[3*CW-1:2*CW];
  assign ry_o = rdata_q[2*CW-1:CW];
  assign rz_o = rdata_q[CW-1:0];

endmodule

[hw/rtl/vna_cross.sv]
// Cross product unit: (p1-p0) x (q1-q0) in three register stages.
// Corner vertices arrive one beat per slot from the vertex store. No package use.
`timescale 1ns / 1ps

module vna_cross #(
  parameter int CW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vtx_valid_i,
  input  logic [1:0]              vtx_slot_i,
  input  logic signed [CW-1:0]    vx_i,
  input  logic signed [CW-1:0]    vy_i,
  input  logic signed [CW-1:0]    vz_i,
  input  logic                    go_i,
  output logic                    done_o,
  output logic signed [2*CW+2:0]  nx_o,
  output logic signed [2*CW+2:0]  ny_o,
  output logic signed [2*CW+2:0]  nz_o
);

  localparam int DFW     = CW + 1;
  localparam int PW      = 2 * CW + 2;
  localparam int CROSS_W = 2 * CW + 3;

  // slots: 0 p0, 1 p1, 2 q0, 3 q1
  logic signed [CW-1:0] vx_q [4];
  logic signed [CW-1:0] vy_q [4];
  logic signed [CW-1:0] vz_q [4];

  logic signed [DFW-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
  logic signed [PW-1:0]  p_q [6];
  logic signed [CROSS_W-1:0] nx_q, ny_q, nz_q;
  logic [2:0] v_q;

  always_ff @(posedge clk_i) begin
    if (vtx_valid_i) begin
      vx_q[vtx_slot_i] <= vx_i;
      vy_q[vtx_slot_i] <= vy_i;
      vz_q[vtx_slot_i] <= vz_i;
    end
    if (go_i) begin
      ux_q <= DFW'(vx_q[1]) - DFW'(vx_q[0]);
      uy_q <= DFW'(vy_q[1]) - DFW'(vy_q[0]);
      uz_q <= DFW'(vz_q[1]) - DFW'(vz_q[0]);
      wx_q <= DFW'(vx_q[3]) - DFW'(vx_q[2]);
      wy_q <= DFW'(vy_q[3]) - DFW'(vy_q[2]);
      wz_q <= DFW'(vz_q[3]) - DFW'(vz_q[2]);
    end
    if (v_q[0]) begin
      p_q[0] <= PW'(uy_q) * PW'(wz_q);
      p_q[1] <= PW'(uz_q) * PW'(wy_q);
      p_q[2] <= PW'(uz_q) * PW'(wx_q);
      p_q[3] <= PW'(ux_q) * PW'(wz_q);
      p_q[4] <= PW'(ux_q) * PW'(wy_q);
      p_q[5] <= PW'(uy_q) * PW'(wx_q);
    end
    if (v_q[1]) begin
      nx_q <= CROSS_W'(p_q[0]) - CROSS_W'(p_q[1]);
      ny_q <= CROSS_W'(p_q[2]) - CROSS_W'(p_q[3]);
      nz_q <= CROSS_W'(p_q[4]) - CROSS_W'(p_q[5]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], go_i};
    end
  end

  assign done_o = v_q[2];
  assign nx_o   = nx_q;
  assign ny_o   = ny_q;
  assign nz_o   = nz_q;

endmodule

[hw/rtl/vna_normal_acc.sv]
// Normal accumulator store with read-modify-write and saturating add.
// One write port, one read port; forwards the previous write. Uses vna_pkg.
`timescale 1ns / 1ps

module vna_normal_acc import vna_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int CW    = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nrm_req_t                 req_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic signed [2*CW+2:0]   add_x_i,
  input  logic signed [2*CW+2:0]   add_y_i,
  input  logic signed [2*CW+2:0]   add_z_i,
  output acc_vec_t                 rd_o,
  output logic                     sat_o
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CROSS_W = 2 * CW + 3;
  localparam int SUM_W   = ((CROSS_W > ACC_W) ? CROSS_W : ACC_W) + 1;

  acc_vec_t mem [DEPTH];
  acc_vec_t rdata_q;
  acc_vec_t fwd_data_q;
  logic [IDX_W-1:0] p_addr_q;
  logic [IDX_W-1:0] fwd_addr_q;
  logic p_acc_q;
  logic fwd_v_q;

  acc_vec_t base;
  acc_vec_t sum;
  logic [ACC_W:0] rx, ry, rz;

  // Returns {clamped, value}.
  function automatic logic [ACC_W:0] sat_add(logic signed [ACC_W-1:0] a,
                                             logic signed [CROSS_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    logic [ACC_W:0] r;
    s = SUM_W'(a) + SUM_W'(b);
    if (s[SUM_W-1:ACC_W-1] == '0 || s[SUM_W-1:ACC_W-1] == '1) begin
      r = {1'b0, s[ACC_W-1:0]};
    end else if (s[SUM_W-1]) begin
      r = {1'b1, ACC_MIN};
    end else begin
      r = {1'b1, ACC_MAX};
    end
    return r;
  endfunction

  always_comb begin
    // The read of this entry raced last cycle's write: take the written value.
    base  = (fwd_v_q && fwd_addr_q == p_addr_q) ? fwd_data_q : rdata_q;
    rx    = sat_add(base.x, add_x_i);
    ry    = sat_add(base.y, add_y_i);
    rz    = sat_add(base.z, add_z_i);
    sum.x = rx[ACC_W-1:0];
    sum.y = ry[ACC_W-1:0];
    sum.z = rz[ACC_W-1:0];
    sat_o = p_acc_q && (rx[ACC_W] || ry[ACC_W] || rz[ACC_W]);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.clr_en) begin
      mem[addr_i] <= '0;
    end else if (p_acc_q) begin
      mem[p_addr_q] <= sum;
    end
    if (req_i.rd_en || req_i.acc_en) begin
      rdata_q <= mem[addr_i];
    end
    p_addr_q   <= addr_i;
    fwd_addr_q <= p_addr_q;
    fwd_data_q <= sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_acc_q <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      p_acc_q <= req_i.acc_en;
      fwd_v_q <= p_acc_q;
    end
  end

  assign rd_o = rdata_q;

endmodule

[hw/rtl/vertex_normal_accumulator.sv]
// Area-weighted vertex normal accumulator. Commands: load vertex, clear normals,
// triangle, quad, read normal; one result beat per command. An item holds the
// block from its accept beat until its result beat can be sent; the two
// index-wrap steps, the four vertex-store reads on the single read port, the
// three-stage cross product and one normal-store update per corner on the
// single write port set the length of that hold. Clear sweeps the normal store
// one entry per cycle. Accumulators saturate to 48 bits and flag status.
// Uses vna_pkg, vna_wrap, vna_vertex_mem, vna_cross and vna_normal_acc.
`timescale 1ns / 1ps

module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int NORMAL_DEPTH = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              command_i,
  input  logic [RAW_IDX_W-1:0]    vertex_a_i,
  input  logic [RAW_IDX_W-1:0]    vertex_b_i,
  input  logic [RAW_IDX_W-1:0]    vertex_c_i,
  input  logic [RAW_IDX_W-1:0]    vertex_d_i,
  input  logic [RAW_IDX_W-1:0]    normal_a_i,
  input  logic [RAW_IDX_W-1:0]    normal_b_i,
  input  logic [RAW_IDX_W-1:0]    normal_c_i,
  input  logic [RAW_IDX_W-1:0]    normal_d_i,
  input  logic signed [FIELD_CW-1:0] coord_x_i,
  input  logic signed [FIELD_CW-1:0] coord_y_i,
  input  logic signed [FIELD_CW-1:0] coord_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] sum_x_o,
  output logic signed [ACC_W-1:0] sum_y_o,
  output logic signed [ACC_W-1:0] sum_z_o,
  output logic                    status_o
);

  localparam int VIDX_W  = $clog2(VERTEX_DEPTH);
  localparam int NIDX_W  = $clog2(NORMAL_DEPTH);
  localparam int CROSS_W = 2 * COORD_WIDTH + 3;
  localparam int LOAD_W  = (COORD_WIDTH < FIELD_CW) ? COORD_WIDTH : FIELD_CW;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_CLEAR = 3'd1,
    CMD_TRI   = 3'd2,
    CMD_QUAD  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDX1, ST_IDX2, ST_LOAD, ST_VREAD, ST_VLAST, ST_CGO, ST_CWAIT,
    ST_ACC, ST_ADRAIN, ST_NREAD, ST_NRDATA, ST_CLEAR, ST_DONE
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic [1:0] cnt_q;
  logic [NIDX_W-1:0] clr_q;
  logic rd_v_q;
  logic [1:0] rd_slot_q;
  logic flag_q;
  logic signed [FIELD_CW-1:0] cx_q, cy_q, cz_q;
  acc_vec_t res_q;
  logic out_valid_q;
  acc_vec_t out_q;
  logic status_q;

  logic accept;
  logic is_quad;
  logic can_out;

  logic [VIDX_W-1:0] va, vb, vc, vd;
  logic [NIDX_W-1:0] na, nb, nc, nd;

  logic vtx_we, vtx_re;
  logic [VIDX_W-1:0] vtx_raddr;
  logic signed [COORD_WIDTH-1:0] wx, wy, wz;
  logic signed [COORD_WIDTH-1:0] rx, ry, rz;

  logic cross_go, cross_done;
  logic signed [CROSS_W-1:0] nx, ny, nz;

  nrm_req_t nreq;
  logic [NIDX_W-1:0] naddr;
  logic [NIDX_W-1:0] corner;
  acc_vec_t nrd;
  logic sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign is_quad    = (cmd_q == CMD_QUAD);
  assign can_out    = !out_valid_q || !out_stall_i;

  vna_wrap #(.DEPTH(VERTEX_DEPTH)) u_wrap_va (
    .clk_i(clk_i), .en_i(accept), .raw_i(vertex_a_i), .idx_o(va));
  vna_wrap #(.DEPTH(VERTEX_DEPTH)) u_wrap_vb (
    .clk_i(clk_i), .en_i(accept), .raw_i(vertex_b_i), .idx_o(vb));
  vna_wrap #(.DEPTH(VERTEX_DEPTH)) u_wrap_vc (
    .clk_i(clk_i), .en_i(accept), .raw_i(vertex_c_i), .idx_o(vc));
  vna_wrap #(.DEPTH(VERTEX_DEPTH)) u_wrap_vd (
    .clk_i(clk_i), .en_i(accept), .raw_i(vertex_d_i), .idx_o(vd));
  vna_wrap #(.DEPTH(NORMAL_DEPTH)) u_wrap_na (
    .clk_i(clk_i), .en_i(accept), .raw_i(normal_a_i), .idx_o(na));
  vna_wrap #(.DEPTH(NORMAL_DEPTH)) u_wrap_nb (
    .clk_i(clk_i), .en_i(accept), .raw_i(normal_b_i), .idx_o(nb));
  vna_wrap #(.DEPTH(NORMAL_DEPTH)) u_wrap_nc (
    .clk_i(clk_i), .en_i(accept), .raw_i(normal_c_i), .idx_o(nc));
  vna_wrap #(.DEPTH(NORMAL_DEPTH)) u_wrap_nd (
    .clk_i(clk_i), .en_i(accept), .raw_i(normal_d_i), .idx_o(nd));

  // Loaded coordinates are sign-extended from the narrower of the two widths.
  assign wx = COORD_WIDTH'($signed(cx_q[LOAD_W-1:0]));
  assign wy = COORD_WIDTH'($signed(cy_q[LOAD_W-1:0]));
  assign wz = COORD_WIDTH'($signed(cz_q[LOAD_W-1:0]));

  assign vtx_we = (state_q == ST_LOAD);
  assign vtx_re = (state_q == ST_VREAD);

  // triangle: p0 a, p1 b, q0 a, q1 c; quad: p0 a, p1 c, q0 b, q1 d
  always_comb begin
    case (cnt_q)
      2'd0:    vtx_raddr = va;
      2'd1:    vtx_raddr = is_quad ? vc : vb;
      2'd2:    vtx_raddr = is_quad ? vb : va;
      default: vtx_raddr = is_quad ? vd : vc;
    endcase
  end

  vna_vertex_mem #(.DEPTH(VERTEX_DEPTH), .CW(COORD_WIDTH)) u_vertex_mem (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (va),
    .wx_i    (wx),
    .wy_i    (wy),
    .wz_i    (wz),
    .re_i    (vtx_re),
    .raddr_i (vtx_raddr),
    .rx_o    (rx),
    .ry_o    (ry),
    .rz_o    (rz)
  );

  assign cross_go = (state_q == ST_CGO);

  vna_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_valid_i (rd_v_q),
    .vtx_slot_i  (rd_slot_q),
    .vx_i        (rx),
    .vy_i        (ry),
    .vz_i        (rz),
    .go_i        (cross_go),
    .done_o      (cross_done),
    .nx_o        (nx),
    .ny_o        (ny),
    .nz_o        (nz)
  );

  always_comb begin
    case (cnt_q)
      2'd0:    corner = na;
      2'd1:    corner = nb;
      2'd2:    corner = nc;
      default: corner = nd;
    endcase
  end

  always_comb begin
    nreq.rd_en  = (state_q == ST_NREAD);
    nreq.acc_en = (state_q == ST_ACC);
    nreq.clr_en = (state_q == ST_CLEAR);
    if (state_q == ST_CLEAR) begin
      naddr = clr_q;
    end else if (state_q == ST_ACC) begin
      naddr = corner;
    end else begin
      naddr = na;
    end
  end

  vna_normal_acc #(.DEPTH(NORMAL_DEPTH), .CW(COORD_WIDTH)) u_normal_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (nreq),
    .addr_i  (naddr),
    .add_x_i (nx),
    .add_y_i (ny),
    .add_z_i (nz),
    .rd_o    (nrd),
    .sat_o   (sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_LOAD;
      cnt_q       <= '0;
      clr_q       <= '0;
      rd_v_q      <= 1'b0;
      rd_slot_q   <= '0;
      flag_q      <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      status_q    <= 1'b0;
    end else begin
      rd_v_q    <= (state_q == ST_VREAD);
      rd_slot_q <= cnt_q;
      flag_q    <= accept ? 1'b0 : (flag_q | sat);

      if (state_q == ST_DONE && can_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_e'(command_i);
            cx_q    <= coord_x_i;
            cy_q    <= coord_y_i;
            cz_q    <= coord_z_i;
            res_q   <= '0;
            state_q <= ST_IDX1;
          end
        end
        ST_IDX1: begin
          state_q <= ST_IDX2;
        end
        ST_IDX2: begin
          cnt_q <= '0;
          clr_q <= '0;
          case (cmd_q)
            CMD_LOAD:  state_q <= ST_LOAD;
            CMD_CLEAR: state_q <= ST_CLEAR;
            CMD_TRI:   state_q <= ST_VREAD;
            CMD_QUAD:  state_q <= ST_VREAD;
            CMD_READ:  state_q <= ST_NREAD;
            default:   state_q <= ST_DONE;
          endcase
        end
        ST_LOAD: begin
          state_q <= ST_DONE;
        end
        ST_VREAD: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_VLAST;
          end
        end
        ST_VLAST: begin
          state_q <= ST_CGO;
        end
        ST_CGO: begin
          state_q <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (cross_done) begin
            cnt_q   <= '0;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == (is_quad ? 2'd3 : 2'd2)) begin
            state_q <= ST_ADRAIN;
          end
        end
        ST_ADRAIN: begin
          // last corner's write-back lands here
          state_q <= ST_DONE;
        end
        ST_NREAD: begin
          state_q <= ST_NRDATA;
        end
        ST_NRDATA: begin
          res_q   <= nrd;
          state_q <= ST_DONE;
        end
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == NIDX_W'(NORMAL_DEPTH - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_out) begin
            out_q    <= res_q;
            status_q <= flag_q;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_x_o     = out_q.x;
  assign sum_y_o     = out_q.y;
  assign sum_z_o     = out_q.z;
  assign status_o    = status_q;

endmodule

[test/tb_vertex_normal_accumulator.sv]
// Self-checking bench for vertex_normal_accumulator: directed corners, a random command mix,
// output back-pressure and two runs of extreme quads that build large sums, each on one entry.
// Depends on vna_pkg and the vertex_normal_accumulator RTL.
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator;
  import vna_pkg::*;

  localparam int VTX_DEPTH        = 1024;
  localparam int NRM_DEPTH        = 1024;
  // Slowest gap between beats is a clear sweep plus a hold-off; keep a wide margin.
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int DRAIN_CYCLES     = NRM_DEPTH + 32;
  localparam int RANDOM_PER_PHASE = 220;
  // Each extreme quad adds about 2^33 four times to one entry.
  localparam int EXTREME_QUADS    = 20;

  localparam longint ACC_HI = longint'(signed'(ACC_MAX));
  localparam longint ACC_LO = longint'(signed'(ACC_MIN));

  typedef enum logic [2:0] {
    CMD_LOAD, CMD_CLEAR, CMD_TRI, CMD_QUAD, CMD_READ, CMD_RSVD5, CMD_RSVD6, CMD_RSVD7
  } vna_cmd_e;

  typedef struct {
    vna_cmd_e                   cmd;
    logic [RAW_IDX_W-1:0]       va, vb, vc, vd;
    logic [RAW_IDX_W-1:0]       na, nb, nc, nd;
    logic signed [FIELD_CW-1:0] cx, cy, cz;
  } prim_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] sx;
    logic [ACC_W-1:0] sy;
    logic [ACC_W-1:0] sz;
    logic             st;
  } normal_beat_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [2:0]                 command_i;
  logic [RAW_IDX_W-1:0]       vertex_a_i, vertex_b_i, vertex_c_i, vertex_d_i;
  logic [RAW_IDX_W-1:0]       normal_a_i, normal_b_i, normal_c_i, normal_d_i;
  logic signed [FIELD_CW-1:0] coord_x_i, coord_y_i, coord_z_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [ACC_W-1:0]    sum_x_o, sum_y_o, sum_z_o;
  logic                       status_o;

  vertex_normal_accumulator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .vertex_c_i  (vertex_c_i),
    .vertex_d_i  (vertex_d_i),
    .normal_a_i  (normal_a_i),
    .normal_b_i  (normal_b_i),
    .normal_c_i  (normal_c_i),
    .normal_d_i  (normal_d_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_x_o     (sum_x_o),
    .sum_y_o     (sum_y_o),
    .sum_z_o     (sum_z_o),
    .status_o    (status_o)
  );

  // Shadow of the block state
  longint vtx_x [VTX_DEPTH];
  longint vtx_y [VTX_DEPTH];
  longint vtx_z [VTX_DEPTH];
  longint nrm_x [NRM_DEPTH];
  longint nrm_y [NRM_DEPTH];
  longint nrm_z [NRM_DEPTH];
  bit     sat_hit;

  // Stimulus bookkeeping: only loaded vertices are ever referenced
  bit                   vtx_loaded [VTX_DEPTH];
  logic [RAW_IDX_W-1:0] loaded_idx [$];

  prim_item_t   pending_items [$];
  normal_beat_t expected_normals [$];
  int unsigned  items_queued;
  int unsigned  items_accepted;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_off_left;
  int unsigned  mismatches;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp_acc(input longint s);
    if (s > ACC_HI) begin
      sat_hit = 1'b1;
      return ACC_HI;
    end
    if (s < ACC_LO) begin
      sat_hit = 1'b1;
      return ACC_LO;
    end
    return s;
  endfunction

  // n = (v[p1] - v[p0]) x (v[q1] - v[q0])
  function automatic void cross_product(input logic [RAW_IDX_W-1:0] p0, p1, q0, q1,
                                        output longint nx, ny, nz);
    longint ux, uy, uz, wx, wy, wz;
    ux = vtx_x[p1] - vtx_x[p0];
    uy = vtx_y[p1] - vtx_y[p0];
    uz = vtx_z[p1] - vtx_z[p0];
    wx = vtx_x[q1] - vtx_x[q0];
    wy = vtx_y[q1] - vtx_y[q0];
    wz = vtx_z[q1] - vtx_z[q0];
    nx = uy * wz - uz * wy;
    ny = uz * wx - ux * wz;
    nz = ux * wy - uy * wx;
  endfunction

  function automatic void add_to_entry(input logic [RAW_IDX_W-1:0] e,
                                       input longint nx, ny, nz);
    nrm_x[e] = clamp_acc(nrm_x[e] + nx);
    nrm_y[e] = clamp_acc(nrm_y[e] + ny);
    nrm_z[e] = clamp_acc(nrm_z[e] + nz);
  endfunction

  function automatic normal_beat_t predict_normal_beat(input prim_item_t it);
    normal_beat_t r;
    longint       nx, ny, nz;
    r       = '0;
    sat_hit = 1'b0;
    case (it.cmd)
      CMD_LOAD: begin
        vtx_x[it.va] = longint'(it.cx);
        vtx_y[it.va] = longint'(it.cy);
        vtx_z[it.va] = longint'(it.cz);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NRM_DEPTH; i++) begin
          nrm_x[i] = 0;
          nrm_y[i] = 0;
          nrm_z[i] = 0;
        end
      end
      CMD_TRI: begin
        cross_product(it.va, it.vb, it.va, it.vc, nx, ny, nz);
        add_to_entry(it.na, nx, ny, nz);
        add_to_entry(it.nb, nx, ny, nz);
        add_to_entry(it.nc, nx, ny, nz);
      end
      CMD_QUAD: begin
        cross_product(it.va, it.vc, it.vb, it.vd, nx, ny, nz);
        add_to_entry(it.na, nx, ny, nz);
        add_to_entry(it.nb, nx, ny, nz);
        add_to_entry(it.nc, nx, ny, nz);
        add_to_entry(it.nd, nx, ny, nz);
      end
      CMD_READ: begin
        r.sx = ACC_W'(nrm_x[it.na]);
        r.sy = ACC_W'(nrm_y[it.na]);
        r.sz = ACC_W'(nrm_z[it.na]);
      end
      default: ;
    endcase
    r.st = sat_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one beat at a time, prediction at the accepting edge
  // ---------------------------------------------------------------------------
  initial begin : beat_driver
    prim_item_t cur;
    bit         holding;
    holding    = 1'b0;
    in_valid_i = 1'b0;
    command_i  = '0;
    vertex_a_i = '0;
    vertex_b_i = '0;
    vertex_c_i = '0;
    vertex_d_i = '0;
    normal_a_i = '0;
    normal_b_i = '0;
    normal_c_i = '0;
    normal_d_i = '0;
    coord_x_i  = '0;
    coord_y_i  = '0;
    coord_z_i  = '0;
    forever begin
      @(negedge clk_i);
      if (!holding && pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur        = pending_items.pop_front();
        holding    = 1'b1;
        command_i  <= cur.cmd;
        vertex_a_i <= cur.va;
        vertex_b_i <= cur.vb;
        vertex_c_i <= cur.vc;
        vertex_d_i <= cur.vd;
        normal_a_i <= cur.na;
        normal_b_i <= cur.nb;
        normal_c_i <= cur.nc;
        normal_d_i <= cur.nd;
        coord_x_i  <= cur.cx;
        coord_y_i  <= cur.cy;
        coord_z_i  <= cur.cz;
        in_valid_i <= 1'b1;
      end else if (!holding) begin
        in_valid_i <= 1'b0;
      end
      @(posedge clk_i);
      if (holding && !in_stall_o) begin
        expected_normals = {expected_normals, predict_normal_beat(cur)};
        holding = 1'b0;
        items_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall plus a counted hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_stall
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [ACC_W-1:0] want,
                                      input logic [ACC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    normal_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h %h %h %b",
                 $time, sum_x_o, sum_y_o, sum_z_o, status_o);
        mismatches++;
      end else begin
        want = expected_normals.pop_front();
        check_field("sum_x", want.sx, sum_x_o);
        check_field("sum_y", want.sy, sum_y_o);
        check_field("sum_z", want.sz, sum_z_o);
        check_field("status", ACC_W'(want.st), ACC_W'(status_o));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  task automatic send_item(input prim_item_t it);
    int unsigned ticket;
    ticket       = items_queued + 1;
    items_queued = ticket;
    pending_items = {pending_items, it};
    wait (items_accepted >= ticket);
  endtask

  task automatic wait_drained();
    wait (items_accepted == items_queued && expected_normals.size() == 0);
  endtask

  // Unused fields carry random bits so every bit toggles
  function automatic prim_item_t noise_item();
    prim_item_t it;
    it.cmd = CMD_LOAD;
    it.va  = RAW_IDX_W'($urandom);
    it.vb  = RAW_IDX_W'($urandom);
    it.vc  = RAW_IDX_W'($urandom);
    it.vd  = RAW_IDX_W'($urandom);
    it.na  = RAW_IDX_W'($urandom);
    it.nb  = RAW_IDX_W'($urandom);
    it.nc  = RAW_IDX_W'($urandom);
    it.nd  = RAW_IDX_W'($urandom);
    it.cx  = FIELD_CW'($urandom);
    it.cy  = FIELD_CW'($urandom);
    it.cz  = FIELD_CW'($urandom);
    return it;
  endfunction

  task automatic send_load(input logic [RAW_IDX_W-1:0] idx,
                           input logic signed [FIELD_CW-1:0] x, y, z);
    prim_item_t it;
    it     = noise_item();
    it.cmd = CMD_LOAD;
    it.va  = idx;
    it.cx  = x;
    it.cy  = y;
    it.cz  = z;
    if (!vtx_loaded[idx]) begin
      vtx_loaded[idx] = 1'b1;
      loaded_idx = {loaded_idx, idx};
    end
    send_item(it);
  endtask

  task automatic send_clear();
    prim_item_t it;
    it     = noise_item();
    it.cmd = CMD_CLEAR;
    send_item(it);
  endtask

  task automatic send_tri(input logic [RAW_IDX_W-1:0] va, vb, vc, na, nb, nc);
    prim_item_t it;
    it     = noise_item();
    it.cmd = CMD_TRI;
    it.va  = va;
    it.vb  = vb;
    it.vc  = vc;
    it.na  = na;
    it.nb  = nb;
    it.nc  = nc;
    send_item(it);
  endtask

  task automatic send_quad(input logic [RAW_IDX_W-1:0] va, vb, vc, vd, na, nb, nc, nd);
    prim_item_t it;
    it     = noise_item();
    it.cmd = CMD_QUAD;
    it.va  = va;
    it.vb  = vb;
    it.vc  = vc;
    it.vd  = vd;
    it.na  = na;
    it.nb  = nb;
    it.nc  = nc;
    it.nd  = nd;
    send_item(it);
  endtask

  task automatic send_read(input logic [RAW_IDX_W-1:0] e);
    prim_item_t it;
    it     = noise_item();
    it.cmd = CMD_READ;
    it.na  = e;
    send_item(it);
  endtask

  task automatic send_unknown(input vna_cmd_e cmd);
    prim_item_t it;
    it     = noise_item();
    it.cmd = cmd;
    send_item(it);
  endtask

  function automatic logic [RAW_IDX_W-1:0] pick_vertex();
    return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
  endfunction

  // Mostly a small hot set so reads see accumulated sums
  function automatic logic [RAW_IDX_W-1:0] pick_normal();
    if ($urandom_range(0, 99) < 70) return RAW_IDX_W'($urandom_range(0, 15));
    return RAW_IDX_W'($urandom_range(0, NRM_DEPTH - 1));
  endfunction

  function automatic logic signed [FIELD_CW-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return FIELD_CW'($signed($urandom_range(0, 4095)) - 2048);
      default: return FIELD_CW'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 24)
      send_load(RAW_IDX_W'($urandom_range(0, VTX_DEPTH - 1)),
                pick_coord(), pick_coord(), pick_coord());
    else if (pick < 54)
      send_tri(pick_vertex(), pick_vertex(), pick_vertex(),
               pick_normal(), pick_normal(), pick_normal());
    else if (pick < 80)
      send_quad(pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex(),
                pick_normal(), pick_normal(), pick_normal(), pick_normal());
    else if (pick < 92)
      send_read(pick_normal());
    else if (pick < 94)
      send_clear();
    else
      send_unknown(vna_cmd_e'($urandom_range(CMD_RSVD5, CMD_RSVD7)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_primitives();
    send_load(0, 0, 0, 0);
    send_load(1, 256, 0, 0);
    send_load(2, 0, 256, 0);
    send_load(3, 256, 256, 0);
    send_load(VTX_DEPTH - 1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_load(512, 16'sh8000, 16'sh8000, 16'sh8000);
    send_clear();
    send_read(0);
    send_tri(0, 1, 2, 0, 1, 2);
    send_quad(0, 1, 3, 2, 3, 4, 5, NRM_DEPTH - 1);
    // same entry named more than once in one primitive
    send_tri(512, VTX_DEPTH - 1, 2, 10, 10, 10);
    send_quad(512, 0, VTX_DEPTH - 1, 3, 11, 11, 12, 12);
    // degenerate triangle, zero area
    send_tri(1, 1, 1, 13, 13, 13);
    send_read(NRM_DEPTH - 1);
    send_read(10);
    send_read(12);
    send_load(0, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_tri(0, 1, 2, 0, 0, 1);
    send_read(0);
    send_clear();
    send_read(10);
  endtask

  task automatic test_unknown_commands();
    send_unknown(CMD_RSVD5);
    send_unknown(CMD_RSVD6);
    send_unknown(CMD_RSVD7);
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_random_item();
  endtask

  // Receiver holds off long enough that the block backs up onto its input
  task automatic test_output_backpressure();
    wait_drained();
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (8) send_random_item();
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (5) send_random_item();
    wait_drained();
    repeat (5) send_random_item();
  endtask

  // Extreme quad repeated on one entry, positive, then on a second entry, negative
  task automatic test_extreme_quads();
    send_load(100, 16'sh8000, 16'sh7fff, 0);
    send_load(101, 16'sh8000, 16'sh8000, 0);
    send_load(102, 16'sh7fff, 16'sh8000, 0);
    send_load(103, 16'sh7fff, 16'sh7fff, 0);
    send_clear();
    repeat (EXTREME_QUADS) send_quad(100, 101, 102, 103, 900, 900, 900, 900);
    send_read(900);
    // swapping the second pair flips the normal
    repeat (EXTREME_QUADS) send_quad(100, 103, 102, 101, 901, 901, 901, 901);
    send_read(901);
  endtask

  initial begin
    rst_ni         = 1'b0;
    items_queued   = 0;
    items_accepted = 0;
    hold_off_left  = 0;
    mismatches     = 0;
    send_idle_pct  = 10;
    recv_idle_pct  = 69;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_primitives();
    test_unknown_commands();
    test_random_mix(RANDOM_PER_PHASE);
    test_output_backpressure();

    wait_drained();
    send_idle_pct = 69;
    recv_idle_pct = 10;
    test_random_mix(RANDOM_PER_PHASE);
    test_drain_pause();

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_PER_PHASE);
    test_extreme_quads();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
